FILE: design/wrs_pkg.sv
// Shared types and constants for the windowed residual statistics block.
// No dependencies.
`timescale 1ns / 1ps
package wrs_pkg;

	localparam int unsigned MAX_TRACKS = 65536;
	localparam int unsigned MAX_SLOTS  = 64;
	localparam int unsigned TALLY_W    = 17;
	localparam logic [TALLY_W-1:0] TALLY_CAP =
		(MAX_TRACKS < 131071) ? TALLY_W'(MAX_TRACKS) : TALLY_W'(131071);
	localparam int unsigned CFG_AW = 3;
	localparam int unsigned CFG_DW = 32;

	typedef enum logic [CFG_AW-1:0] {
		REG_CHI_LIMIT   = 3'd0,
		REG_RES_WINDOW  = 3'd1,
		REG_NSENS_XY    = 3'd2,
		REG_NSENS_U     = 3'd3,
		REG_VIEW_SEL    = 3'd4,
		REG_SENSOR      = 3'd5,
		REG_FIT_2DY     = 3'd6
	} reg_idx_t;

	typedef enum logic [1:0] {
		CHI_FINITE = 2'd0,
		CHI_NAN    = 2'd1,
		CHI_SATMAX = 2'd2
	} chi_state_t;

	typedef struct packed {
		logic [31:0]        chi_sq;
		logic [1:0]         chi_state;
		logic [5:0]         slot;
		logic signed [23:0] resid;
		logic               resid_present;
		logic               track_end;
		logic               set_end;
	} in_item_t;

	typedef struct packed {
		logic [47:0]        chi_sum;
		logic [16:0]        chi_count;
		logic [31:0]        chi_mean_limited;
		logic               chi_mean_ok;
		logic signed [23:0] resid_mean;
		logic               resid_mean_ok;
		logic [23:0]        resid_rms;
		logic               resid_rms_ok;
	} out_item_t;

	// classified word handed from the front to the back
	typedef struct packed {
		logic [31:0]        chi_sq;
		logic               chi_add;
		logic               chi_below;
		logic signed [23:0] resid;
		logic [22:0]        mag;
		logic               mean_add;
		logic               rms_add;
		logic               set_end;
	} cls_t;

	// totals snapshot taken at set end
	typedef struct packed {
		logic [47:0]        chi_total;
		logic [16:0]        chi_tally;
		logic [47:0]        below_total;
		logic [16:0]        below_tally;
		logic signed [40:0] mean_total;
		logic [16:0]        mean_tally;
		logic signed [40:0] rms_total;
		logic [63:0]        sq_total;
		logic [16:0]        rms_tally;
	} snap_t;

	typedef enum logic [3:0] {
		F_IDLE, F_DIV_CHI, F_DIV_MEAN, F_MUL_A, F_MUL_B, F_MUL_C,
		F_MUL_D, F_DIFF, F_DIV_RMS, F_SQRT, F_DONE
	} fin_state_t;

endpackage

FILE: design/wrs_front.sv
// Front end: classifies each input word against configuration.
// Depends on wrs_pkg.
`timescale 1ns / 1ps
module wrs_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [wrs_pkg::CFG_AW-1:0] cfg_idx,
	input  logic [wrs_pkg::CFG_DW-1:0] cfg_data,
	input  wrs_pkg::in_item_t        item,
	output wrs_pkg::cls_t            cls
);
	import wrs_pkg::*;

	logic [31:0] chi_limit_q;
	logic [22:0] window_q;
	logic [4:0]  nxy_q, nu_q;
	logic [1:0]  view_q;
	logic [5:0]  sensor_q;
	logic        fit2dy_q;
	logic [7:0]  sel;
	logic [23:0] mag;
	logic        hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chi_limit_q <= '1;
			window_q    <= '1;
			nxy_q       <= '0;
			nu_q        <= '0;
			view_q      <= '0;
			sensor_q    <= '0;
			fit2dy_q    <= 1'b0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_idx))
				REG_CHI_LIMIT:  chi_limit_q <= cfg_data;
				REG_RES_WINDOW: window_q    <= cfg_data[22:0];
				REG_NSENS_XY:   nxy_q       <= cfg_data[4:0];
				REG_NSENS_U:    nu_q        <= cfg_data[4:0];
				REG_VIEW_SEL:   view_q      <= cfg_data[1:0];
				REG_SENSOR:     sensor_q    <= cfg_data[5:0];
				REG_FIT_2DY:    fit2dy_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (view_q)
			2'd0:    sel = {2'b0, sensor_q};
			2'd1:    sel = fit2dy_q ? {2'b0, sensor_q} : 8'(nxy_q) + 8'(sensor_q);
			2'd2:    sel = {2'b0, nxy_q, 1'b0} + 8'(sensor_q);
			default: sel = {2'b0, nxy_q, 1'b0} + 8'(nu_q) + 8'(sensor_q);
		endcase
		mag = item.resid[23] ? 24'(-item.resid) : item.resid;
		// most negative value gives mag bit 23 set: never inside the window
		hit = item.resid_present && (sel < 8'(MAX_SLOTS)) && (sel[5:0] == item.slot)
			&& !mag[23] && (mag[22:0] <= window_q);
		cls.chi_sq    = item.chi_sq;
		cls.chi_add   = item.track_end && (item.chi_state == CHI_FINITE);
		cls.chi_below = item.chi_sq < chi_limit_q;
		cls.resid     = item.resid;
		cls.mag       = mag[22:0];
		cls.mean_add  = hit && (item.chi_state == CHI_FINITE);
		cls.rms_add   = hit && (item.chi_state == CHI_FINITE || item.chi_state == CHI_SATMAX);
		cls.set_end   = item.set_end;
	end
endmodule

FILE: design/wrs_accum.sv
// Back end accumulator: saturating sums, one classified word per cycle unless a finished snapshot waits.
// Depends on wrs_pkg.
`timescale 1ns / 1ps
module wrs_accum (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           valid,
	input  wrs_pkg::cls_t  cls,
	input  logic           snap_ready,
	output logic           ready,
	output logic           snap_valid,
	output wrs_pkg::snap_t snap
);
	import wrs_pkg::*;

	snap_t acc_q, nxt;
	logic  done_q;
	logic [45:0] sq;

	function automatic logic [16:0] tinc(input logic [16:0] t);
		tinc = (t >= TALLY_CAP) ? TALLY_CAP : t + 17'd1;
	endfunction
	function automatic logic [47:0] add48(input logic [47:0] a, input logic [31:0] b);
		logic [48:0] s;
		s = {1'b0, a} + 49'(b);
		add48 = s[48] ? '1 : s[47:0];
	endfunction
	function automatic logic signed [40:0] adds41(input logic signed [40:0] a,
		input logic signed [23:0] b);
		logic signed [41:0] s;
		s = 42'(a) + 42'(b);
		adds41 = (s[41] != s[40]) ? (s[41] ? {1'b1, 40'b0} : {1'b0, {40{1'b1}}}) : s[40:0];
	endfunction

	// hold accepted words while a finished snapshot waits
	assign ready      = !done_q || snap_ready;
	assign snap_valid = done_q;
	assign snap       = acc_q;
	assign sq         = cls.mag * cls.mag;

	always_comb begin
		logic [64:0] s2;
		nxt = done_q ? '0 : acc_q;
		s2  = '0;
		if (cls.chi_add) begin
			nxt.chi_total = add48(nxt.chi_total, cls.chi_sq);
			nxt.chi_tally = tinc(nxt.chi_tally);
			if (cls.chi_below) begin
				nxt.below_total = add48(nxt.below_total, cls.chi_sq);
				nxt.below_tally = tinc(nxt.below_tally);
			end
		end
		if (cls.mean_add) begin
			nxt.mean_total = adds41(nxt.mean_total, cls.resid);
			nxt.mean_tally = tinc(nxt.mean_tally);
		end
		if (cls.rms_add) begin
			nxt.rms_total = adds41(nxt.rms_total, cls.resid);
			s2 = {1'b0, nxt.sq_total} + 65'(sq);
			nxt.sq_total = s2[64] ? '1 : s2[63:0];
			nxt.rms_tally = tinc(nxt.rms_tally);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			done_q <= 1'b0;
		end else begin
			if (valid && ready) begin
				acc_q  <= nxt;
				done_q <= cls.set_end;
			end else if (done_q && snap_ready) begin
				acc_q  <= '0;
				done_q <= 1'b0;
			end
		end
	end
endmodule

FILE: design/wrs_finish.sv
// Back end finisher: divides, squares and takes the root once per set.
// Depends on wrs_pkg.
`timescale 1ns / 1ps
module wrs_finish (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              snap_valid,
	input  wrs_pkg::snap_t    snap,
	output logic              snap_ready,
	output logic              res_valid,
	output wrs_pkg::out_item_t res,
	input  logic              res_ready
);
	import wrs_pkg::*;

	fin_state_t st_q, st_d;
	snap_t      s_q;
	logic [7:0] cnt_q;
	// shared restoring divider: 128-bit dividend shifts through, 36-bit divisor
	logic [127:0] dvd_q;
	logic [36:0]  rem_q;
	logic [35:0]  dvs_q;
	logic [63:0]  quo_q;
	logic         ovf_q;
	logic [37:0]  rtry;
	logic [127:0] p_q;      // partial product accumulator
	logic [63:0]  sqv_q, sqr_q, sqb_q;
	logic [40:0]  am;
	logic [63:0]  am64;
	logic [31:0]  ma, mb;
	logic [63:0]  mp;
	logic [127:0] t1_q;
	out_item_t    r_q;
	logic         rv_q;

	assign am   = s_q.rms_total[40] ? 41'(-s_q.rms_total) : s_q.rms_total;
	assign am64 = 64'(am);
	assign rtry = {rem_q, dvd_q[127]} - {2'b0, dvs_q};
	assign mp   = ma * mb;

	assign snap_ready = (st_q == F_IDLE) && !rv_q;
	assign res_valid  = rv_q;
	assign res        = r_q;

	always_comb begin
		st_d = st_q;
		ma = '0;
		mb = '0;
		case (st_q)
			F_IDLE:     if (snap_valid && !rv_q) st_d = F_DIV_CHI;
			F_DIV_CHI:  if (cnt_q == 8'd127) st_d = F_DIV_MEAN;
			F_DIV_MEAN: if (cnt_q == 8'd127) st_d = F_MUL_A;
			F_MUL_A: begin
				// one 32x32 partial product per cycle, two for sq_total times rms_tally
				ma = cnt_q[0] ? s_q.sq_total[63:32] : s_q.sq_total[31:0];
				mb = 32'(s_q.rms_tally);
				if (cnt_q == 8'd1) st_d = F_MUL_B;
			end
			F_MUL_B: begin
				ma = cnt_q[1] ? am64[63:32] : am64[31:0];
				mb = cnt_q[0] ? am64[63:32] : am64[31:0];
				if (cnt_q == 8'd3) st_d = F_DIFF;
			end
			F_DIFF:     st_d = F_MUL_C;
			F_MUL_C: begin
				ma = 32'(s_q.rms_tally);
				mb = 32'(s_q.rms_tally - 17'd1);
				st_d = F_DIV_RMS;
			end
			F_DIV_RMS:  if (cnt_q == 8'd127) st_d = F_SQRT;
			F_SQRT:     if (cnt_q == 8'd31) st_d = F_DONE;
			F_DONE:     st_d = F_IDLE;
			default:    st_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= F_IDLE;
			rv_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (rv_q && res_ready) rv_q <= 1'b0;
			else if (st_q == F_DONE) rv_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q != st_d || st_q == F_IDLE) cnt_q <= '0;
		else cnt_q <= cnt_q + 8'd1;
		case (st_q)
			F_IDLE: if (snap_valid && !rv_q) begin
				s_q   <= snap;
				dvd_q <= {80'b0, snap.below_total};
				dvs_q <= 36'(snap.below_tally);
				rem_q <= '0;
				quo_q <= '0;
				ovf_q <= 1'b0;
			end
			F_DIV_CHI, F_DIV_MEAN, F_DIV_RMS: begin
				if (cnt_q == 8'd127) begin
					rem_q <= '0;
					ovf_q <= 1'b0;
					if (st_q == F_DIV_CHI) begin
						r_q.chi_sum     <= s_q.chi_total;
						r_q.chi_count   <= s_q.chi_tally;
						r_q.chi_mean_ok <= s_q.below_tally > 17'd2;
						r_q.chi_mean_limited <= (s_q.below_tally > 17'd2) ?
							((quo_q[62:31] != 32'd0) ? '1 :
							{quo_q[30:0], !rtry[37]}) : '1;
						// next: mean magnitude over tally
						dvd_q <= s_q.mean_total[40] ? 128'(-s_q.mean_total)
							: 128'(s_q.mean_total);
						dvs_q <= 36'(s_q.mean_tally);
						quo_q <= '0;
					end else if (st_q == F_DIV_MEAN) begin
						r_q.resid_mean_ok <= s_q.mean_tally > 17'd2;
						if (s_q.mean_tally <= 17'd2) r_q.resid_mean <= 24'sd8388607;
						else if (s_q.mean_total[40]) begin
							r_q.resid_mean <= ({quo_q[62:0], !rtry[37]} >= 64'd8388608)
								? 24'h800000 : 24'(-{quo_q[62:0], !rtry[37]});
						end else begin
							r_q.resid_mean <= ({quo_q[62:0], !rtry[37]} >= 64'd8388607)
								? 24'sd8388607 : 24'({quo_q[62:0], !rtry[37]});
						end
						p_q <= '0;
					end else begin
						sqv_q <= ovf_q ? '1 : {quo_q[62:0], !rtry[37]};
						sqr_q <= '0;
						sqb_q <= 64'h4000_0000_0000_0000;
					end
				end else begin
					dvd_q <= {dvd_q[126:0], 1'b0};
					quo_q <= {quo_q[62:0], !rtry[37]};
					if (!rtry[37]) begin
						rem_q <= rtry[36:0];
						if (cnt_q < 8'd64) ovf_q <= 1'b1;
					end else rem_q <= {rem_q[35:0], dvd_q[127]};
				end
			end
			F_MUL_A: p_q <= p_q + (128'(mp) << (cnt_q[0] ? 32 : 0));
			F_MUL_B: begin
				if (cnt_q == 8'd0) t1_q <= p_q;
				p_q <= ((cnt_q == 8'd0) ? 128'b0 : p_q)
					+ (128'(mp) << ((cnt_q[1] ? 32 : 0) + (cnt_q[0] ? 32 : 0)));
			end
			F_DIFF: dvd_q <= (t1_q >= p_q) ? t1_q - p_q : p_q - t1_q;
			F_MUL_C: begin
				dvs_q <= 36'(mp);
				quo_q <= '0;
				rem_q <= '0;
				ovf_q <= 1'b0;
			end
			F_SQRT: begin
				// one result bit per step from two radicand bits, over 32 steps
				if (sqv_q >= sqr_q + sqb_q) begin
					sqv_q <= sqv_q - (sqr_q + sqb_q);
					sqr_q <= (sqr_q >> 1) + sqb_q;
				end else sqr_q <= sqr_q >> 1;
				sqb_q <= sqb_q >> 2;
			end
			F_DONE: begin
				r_q.resid_rms_ok <= s_q.rms_tally > 17'd3;
				r_q.resid_rms <= (s_q.rms_tally <= 17'd3 || sqr_q[63:24] != '0)
					? '1 : sqr_q[23:0];
			end
			default: ;
		endcase
	end
endmodule

FILE: design/windowed_residual_statistics.sv
// Windowed residual statistics top level: front classifier, skid queue, back end.
// Depends on wrs_pkg, wrs_front, wrs_accum, wrs_finish.
`timescale 1ns / 1ps
// Takes one residual word per cycle while full is low. Each word is classified at
// once, passes a two-entry queue and is folded into saturating totals. The
// set_end word closes a set; its totals go to a finisher that runs three
// 128-step restoring divisions, a four-step partial-product square and a 32-step
// root while the next set accumulates. Full rises only when a set closes while
// the finisher is still busy with the set before or its result has not been
// popped; the queue then fills from the words that follow. Results leave through
// a one-deep output register read with pop.
module windowed_residual_statistics (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  wrs_pkg::in_item_t          in_item,
	output logic                       empty,
	input  logic                       pop,
	output wrs_pkg::out_item_t         out_item,
	input  logic                       cfg_we,
	input  logic [wrs_pkg::CFG_AW-1:0] cfg_idx,
	input  logic [wrs_pkg::CFG_DW-1:0] cfg_data
);
	import wrs_pkg::*;

	cls_t  cls;
	cls_t  fifo_q [2];
	logic  wp_q, rp_q;
	logic [1:0] cnt_q;
	logic  acc_ready, snap_valid, snap_ready, res_valid;
	snap_t snap;
	logic  do_push, do_pop;

	wrs_front u_front (
		.clk, .arst_n, .cfg_we, .cfg_idx, .cfg_data, .item(in_item), .cls
	);

	assign full    = (cnt_q == 2'd2);
	assign do_push = push && !full;
	assign do_pop  = (cnt_q != 2'd0) && acc_ready;

	always_ff @(posedge clk) begin
		if (do_push) fifo_q[wp_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (do_push) wp_q <= !wp_q;
			if (do_pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

	wrs_accum u_accum (
		.clk, .arst_n, .valid(cnt_q != 2'd0), .cls(fifo_q[rp_q]),
		.snap_ready, .ready(acc_ready), .snap_valid, .snap
	);

	wrs_finish u_finish (
		.clk, .arst_n, .snap_valid, .snap, .snap_ready,
		.res_valid, .res(out_item), .res_ready(pop)
	);

	assign empty = !res_valid;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'd2) else $error("queue count out of range");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		do_pop |-> cnt_q != 2'd0) else $error("queue read while empty");
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !pop) |=> res_valid) else $error("result dropped");
endmodule
